[hw/rtl/btff_pkg.sv]
// Shared constants, types and command codes for the boundary-tag allocator.
`default_nettype none
package btff_pkg;

  localparam int HEAP_WORDS = 1024;
  localparam int ADDR_W     = $clog2(HEAP_WORDS);
  localparam int TAG_W      = ADDR_W + 1;
  localparam int PTR_W      = ADDR_W + 4;
  localparam int SIZE_W     = ADDR_W + 3;
  localparam int CNT_W      = ADDR_W + 1;
  localparam int FIRST_BLK  = 4;
  localparam int MIN_SPLIT  = 4;
  localparam int TAG_WORDS  = 2;
  localparam int TOP_RESET  = 4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_CHK,
    ST_A_EVAL,
    ST_A_GROW,
    ST_F_RD0,
    ST_F_S0,
    ST_F_S1,
    ST_F_S2,
    ST_F_S3,
    ST_F_SET,
    ST_MARK_H,
    ST_MARK_F,
    ST_PUSH
  } ctl_state_t;

  typedef enum logic [4:0] {
    DC_NOP,
    DC_CLEAR,
    DC_LOAD,
    DC_RD_P1,
    DC_STEP,
    DC_SET_EXACT,
    DC_SET_SPLIT,
    DC_SET_GROW,
    DC_SET_FAIL,
    DC_F_S0,
    DC_F_S1,
    DC_F_S2,
    DC_F_S3,
    DC_SET_FREE,
    DC_WR_H,
    DC_WR_F,
    DC_PUSH
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic p_lt_top;
    logic fit_exact;
    logic fit_split;
    logic grow_fail;
    logic has2;
  } dp_status_t;

endpackage
`default_nettype wire

[hw/rtl/btff_dp.sv]
// Datapath of the allocator: tag memory, walk pointer, mark registers, heap top.
`default_nettype none
module btff_dp (
  input  wire                           clk,
  input  wire                           rst_n,
  input  btff_pkg::dp_cmd_t             cmd,
  input  wire                           in_opcode,
  input  wire  [btff_pkg::ADDR_W-1:0]   in_request_words,
  input  wire  [btff_pkg::ADDR_W-1:0]   in_block_address,
  output btff_pkg::dp_status_t          sts,
  output logic [btff_pkg::ADDR_W-1:0]   granted_address,
  output logic                          status
);

  localparam int AW = btff_pkg::ADDR_W;
  localparam int TW = btff_pkg::TAG_W;
  localparam int PW = btff_pkg::PTR_W;
  localparam int SW = btff_pkg::SIZE_W;
  localparam int CW = btff_pkg::CNT_W;

  logic [TW-1:0] mem [btff_pkg::HEAP_WORDS];

  logic [TW-1:0] rdata_r;
  logic [TW-1:0] size_r;
  logic [PW-1:0] p_r,  p_nxt;
  logic [PW-1:0] q_r,  q_nxt;
  logic [SW-1:0] s_r,  s_nxt;
  logic [AW-1:0] top_r, top_nxt;
  logic [CW-1:0] clr_cnt_r;
  logic [PW-1:0] mp_r,  mp_nxt;
  logic [SW-1:0] ms_r,  ms_nxt;
  logic          mu_r,  mu_nxt;
  logic [PW-1:0] mp2_r, mp2_nxt;
  logic [SW-1:0] ms2_r, ms2_nxt;
  logic          mu2_r, mu2_nxt;
  logic          has2_r, has2_nxt;
  logic [AW-1:0] grant_r, grant_nxt;
  logic          stat_r, stat_nxt;
  logic [AW-1:0] out_grant_r;
  logic          out_stat_r;

  logic [TW-1:0] rd_size;
  logic          rd_free;
  logic [PW-1:0] rd_addr_w;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [TW-1:0] wr_data;
  logic [PW-1:0] size_p;
  logic [PW-1:0] rd_size_p;
  logic [PW-1:0] top_p;
  logic [PW-1:0] free_end;
  logic [TW-1:0] mark_val;
  logic [TW:0]   grow_sum;

  assign rd_size   = {rdata_r[TW-1:1], 1'b0};
  assign rd_free   = ~rdata_r[0];
  assign size_p    = PW'(size_r);
  assign rd_size_p = PW'(rd_size);
  assign top_p     = PW'(top_r);
  assign free_end  = p_r + PW'(s_r) + PW'(btff_pkg::TAG_WORDS);
  assign mark_val  = TW'(ms_r) + TW'(mu_r);
  assign grow_sum  = (TW+1)'(top_r) + (TW+1)'(size_r) + (TW+1)'(btff_pkg::TAG_WORDS);

  assign sts.clr_done  = clr_cnt_r[CW-1];
  assign sts.p_lt_top  = p_r < top_p;
  assign sts.fit_exact = rd_free && (size_r == rd_size);
  assign sts.fit_split = rd_free &&
                         ((TW+1)'(size_r) + (TW+1)'(btff_pkg::MIN_SPLIT) <= (TW+1)'(rd_size));
  assign sts.grow_fail = grow_sum >= (TW+1)'(btff_pkg::HEAP_WORDS);
  assign sts.has2      = has2_r;

  assign granted_address = out_grant_r;
  assign status          = out_stat_r;

  // Read address and write port selection.
  always_comb begin
    rd_addr_w = p_r - PW'(1);
    wr_en     = 1'b0;
    wr_addr   = clr_cnt_r[AW-1:0];
    wr_data   = '0;
    unique case (cmd)
      btff_pkg::DC_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = (clr_cnt_r >= CW'(1) && clr_cnt_r <= CW'(4)) ? TW'(1) : '0;
      end
      btff_pkg::DC_F_S0: rd_addr_w = p_r + rd_size_p + PW'(1);
      btff_pkg::DC_F_S1: rd_addr_w = p_r - PW'(btff_pkg::TAG_WORDS);
      btff_pkg::DC_F_S2: rd_addr_w = p_r - PW'(btff_pkg::TAG_WORDS) - rd_size_p - PW'(1);
      btff_pkg::DC_WR_H: begin
        wr_en   = 1'b1;
        wr_addr = AW'(mp_r - PW'(1));
        wr_data = mark_val;
      end
      btff_pkg::DC_WR_F: begin
        wr_en   = 1'b1;
        wr_addr = AW'(mp_r + PW'(ms_r));
        wr_data = mark_val;
      end
      default: ;
    endcase
    rd_addr = rd_addr_w[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    p_nxt     = p_r;
    q_nxt     = q_r;
    s_nxt     = s_r;
    top_nxt   = top_r;
    mp_nxt    = mp_r;
    ms_nxt    = ms_r;
    mu_nxt    = mu_r;
    mp2_nxt   = mp2_r;
    ms2_nxt   = ms2_r;
    mu2_nxt   = mu2_r;
    has2_nxt  = has2_r;
    grant_nxt = grant_r;
    stat_nxt  = stat_r;
    unique case (cmd)
      btff_pkg::DC_LOAD: begin
        p_nxt     = (in_opcode == btff_pkg::OP_FREE) ? PW'(in_block_address)
                                                     : PW'(btff_pkg::FIRST_BLK);
        has2_nxt  = 1'b0;
        grant_nxt = '0;
        stat_nxt  = 1'b0;
      end
      btff_pkg::DC_STEP: p_nxt = p_r + rd_size_p + PW'(btff_pkg::TAG_WORDS);
      btff_pkg::DC_SET_EXACT: begin
        mp_nxt    = p_r;
        ms_nxt    = SW'(rd_size);
        mu_nxt    = 1'b1;
        grant_nxt = p_r[AW-1:0];
      end
      btff_pkg::DC_SET_SPLIT: begin
        mp_nxt    = p_r;
        ms_nxt    = SW'(size_r);
        mu_nxt    = 1'b1;
        mp2_nxt   = p_r + size_p + PW'(btff_pkg::TAG_WORDS);
        ms2_nxt   = SW'(rd_size) - SW'(size_r) - SW'(btff_pkg::TAG_WORDS);
        mu2_nxt   = 1'b0;
        has2_nxt  = 1'b1;
        grant_nxt = p_r[AW-1:0];
      end
      btff_pkg::DC_SET_GROW: begin
        mp_nxt    = top_p;
        ms_nxt    = SW'(size_r);
        mu_nxt    = 1'b1;
        mp2_nxt   = top_p + size_p + PW'(btff_pkg::TAG_WORDS);
        ms2_nxt   = '0;
        mu2_nxt   = 1'b1;
        has2_nxt  = 1'b1;
        grant_nxt = top_r;
        top_nxt   = AW'(grow_sum);
      end
      btff_pkg::DC_SET_FAIL: stat_nxt = 1'b1;
      btff_pkg::DC_F_S0:     s_nxt = SW'(rd_size);
      btff_pkg::DC_F_S1: begin
        if (rd_free) begin
          s_nxt = s_r + SW'(rd_size) + SW'(btff_pkg::TAG_WORDS);
        end
      end
      btff_pkg::DC_F_S2: q_nxt = p_r - PW'(btff_pkg::TAG_WORDS) - rd_size_p;
      btff_pkg::DC_F_S3: begin
        if (rd_free) begin
          s_nxt = s_r + SW'(rd_size) + SW'(btff_pkg::TAG_WORDS);
          p_nxt = q_r;
        end
      end
      btff_pkg::DC_SET_FREE: begin
        mp_nxt  = p_r;
        ms_nxt  = s_r;
        mu_nxt  = 1'b0;
        mp2_nxt = p_r;
        ms2_nxt = '0;
        mu2_nxt = 1'b1;
        // A freed block that reaches the epilogue becomes the new epilogue.
        if (free_end == top_p) begin
          has2_nxt = 1'b1;
          top_nxt  = p_r[AW-1:0];
        end
      end
      btff_pkg::DC_WR_F: begin
        if (has2_r) begin
          mp_nxt   = mp2_r;
          ms_nxt   = ms2_r;
          mu_nxt   = mu2_r;
          has2_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      top_r     <= AW'(btff_pkg::TOP_RESET);
      has2_r    <= 1'b0;
    end else begin
      if (cmd == btff_pkg::DC_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + CW'(1);
      end
      top_r  <= top_nxt;
      has2_r <= has2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == btff_pkg::DC_LOAD) begin
      size_r <= TW'(in_request_words) + TW'(in_request_words[0]);
    end
    // The output register holds a finished result while the next request is worked on.
    if (cmd == btff_pkg::DC_PUSH) begin
      out_grant_r <= grant_r;
      out_stat_r  <= stat_r;
    end
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    s_r     <= s_nxt;
    mp_r    <= mp_nxt;
    ms_r    <= ms_nxt;
    mu_r    <= mu_nxt;
    mp2_r   <= mp2_nxt;
    ms2_r   <= ms2_nxt;
    mu2_r   <= mu2_nxt;
    grant_r <= grant_nxt;
    stat_r  <= stat_nxt;
  end

endmodule
`default_nettype wire

[hw/rtl/btff_ctrl.sv]
// Controller state machine of the allocator: sequences the walk, merges and tag writes.
`default_nettype none
module btff_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  input  wire                   in_opcode,
  input  btff_pkg::dp_status_t  sts,
  output btff_pkg::dp_cmd_t     cmd
);

  btff_pkg::ctl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == btff_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btff_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = btff_pkg::DC_NOP;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      btff_pkg::ST_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = btff_pkg::ST_IDLE;
        end else begin
          cmd = btff_pkg::DC_CLEAR;
        end
      end
      btff_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd       = btff_pkg::DC_LOAD;
          state_nxt = (in_opcode == btff_pkg::OP_FREE) ? btff_pkg::ST_F_RD0
                                                       : btff_pkg::ST_A_CHK;
        end
      end
      btff_pkg::ST_A_CHK: begin
        if (sts.p_lt_top) begin
          cmd       = btff_pkg::DC_RD_P1;
          state_nxt = btff_pkg::ST_A_EVAL;
        end else begin
          state_nxt = btff_pkg::ST_A_GROW;
        end
      end
      btff_pkg::ST_A_EVAL: begin
        priority if (sts.fit_exact) begin
          cmd       = btff_pkg::DC_SET_EXACT;
          state_nxt = btff_pkg::ST_MARK_H;
        end else if (sts.fit_split) begin
          cmd       = btff_pkg::DC_SET_SPLIT;
          state_nxt = btff_pkg::ST_MARK_H;
        end else begin
          cmd       = btff_pkg::DC_STEP;
          state_nxt = btff_pkg::ST_A_CHK;
        end
      end
      btff_pkg::ST_A_GROW: begin
        if (sts.grow_fail) begin
          cmd       = btff_pkg::DC_SET_FAIL;
          state_nxt = btff_pkg::ST_PUSH;
        end else begin
          cmd       = btff_pkg::DC_SET_GROW;
          state_nxt = btff_pkg::ST_MARK_H;
        end
      end
      btff_pkg::ST_F_RD0: begin
        cmd       = btff_pkg::DC_RD_P1;
        state_nxt = btff_pkg::ST_F_S0;
      end
      btff_pkg::ST_F_S0: begin
        cmd       = btff_pkg::DC_F_S0;
        state_nxt = btff_pkg::ST_F_S1;
      end
      btff_pkg::ST_F_S1: begin
        cmd       = btff_pkg::DC_F_S1;
        state_nxt = btff_pkg::ST_F_S2;
      end
      btff_pkg::ST_F_S2: begin
        cmd       = btff_pkg::DC_F_S2;
        state_nxt = btff_pkg::ST_F_S3;
      end
      btff_pkg::ST_F_S3: begin
        cmd       = btff_pkg::DC_F_S3;
        state_nxt = btff_pkg::ST_F_SET;
      end
      btff_pkg::ST_F_SET: begin
        cmd       = btff_pkg::DC_SET_FREE;
        state_nxt = btff_pkg::ST_MARK_H;
      end
      btff_pkg::ST_MARK_H: begin
        cmd       = btff_pkg::DC_WR_H;
        state_nxt = btff_pkg::ST_MARK_F;
      end
      btff_pkg::ST_MARK_F: begin
        cmd = btff_pkg::DC_WR_F;
        if (sts.has2) begin
          state_nxt = btff_pkg::ST_MARK_H;
        end else begin
          state_nxt = btff_pkg::ST_PUSH;
        end
      end
      btff_pkg::ST_PUSH: begin
        // The result waits here until the output register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          cmd           = btff_pkg::DC_PUSH;
          out_valid_nxt = 1'b1;
          state_nxt     = btff_pkg::ST_IDLE;
        end
      end
      default: state_nxt = btff_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/boundary_tag_first_fit_allocator.sv]
// Top level of the boundary-tag first-fit heap allocator.
//
//   channel | ports                                                  | direction
//   in      | in_valid/in_ready, in_opcode, in_request_words,        | request in
//           | in_block_address                                       |
//   out     | out_valid/out_ready, out_granted_address, out_status   | result out
//
// An allocate examines blocks in turn and, if none fits, grows the heap at its top; then 2 or 4 tag
// writes follow, or none when out of memory. A free reads and merges its neighbours, then 2 or 4 writes.
// Last the result moves into the output register, once that register is free or being emptied.
// The tag memory's read is registered, one tag a cycle.
// After reset a clearing pass initialises every tag memory word; no request is taken.
// A request is taken while a result waits; a finished one holds until the output is free.
`default_nettype none
module boundary_tag_first_fit_allocator (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         in_opcode,
  input  wire  [btff_pkg::ADDR_W-1:0] in_request_words,
  input  wire  [btff_pkg::ADDR_W-1:0] in_block_address,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [btff_pkg::ADDR_W-1:0] out_granted_address,
  output logic                        out_status
);

  btff_pkg::dp_cmd_t    cmd;
  btff_pkg::dp_status_t sts;

  btff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd)
  );

  btff_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_opcode        (in_opcode),
    .in_request_words (in_request_words),
    .in_block_address (in_block_address),
    .sts              (sts),
    .granted_address  (out_granted_address),
    .status           (out_status)
  );

endmodule
`default_nettype wire
